// ===== design/mnst_pkg.sv =====
// Shared types and constants for the max non-adjacent sum tree.
// Used by mnst_ctrl, mnst_datapath and the top level; no dependencies.
package mnst_pkg;

	localparam int MODE_W  = 1;
	localparam int POS_W   = 16;
	localparam int VALUE_W = 20;
	localparam int SUM_W   = 36;
	localparam int TOTAL_W = 64;
	localparam int ROW_W   = 4 * SUM_W;   // {both, right, left, none}
	localparam int MAX_TREE_BITS = POS_W; // positions from 2^16 up are unreachable

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LEAF,
		ST_CLIMB,
		ST_ROOT_RD,
		ST_ROOT_LD,
		ST_BEST,
		ST_FINISH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic clr_step;
		logic load;
		logic leaf;
		logic climb;
		logic root_rd;
		logic root_ld;
		logic best;
		logic finish;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clear_last;
		logic in_range;
		logic at_top;
		logic out_free;
	} sts_t;

endpackage

// ===== design/max_nonadjacent_sum_tree.sv =====
// Top level of the max non-adjacent sum tree: controller plus datapath.
// Depends on mnst_pkg, mnst_ctrl and mnst_datapath.
//
//   channel  handshake           payload
//   in       in_valid/in_stall   mode, position, value
//   out      out_valid/out_stall best_sum, running_total
//
// An in-range update writes the leaf row, then climbs the path to the root one tree
// level at a time, set by the store's single write port and the level-to-level
// combine chain, then takes the root maximum and loads the result. An out-of-range
// update reads the root row, loads it, takes the maximum and loads the result.
// After reset a clearing pass writes all 2 * 2^TREE_BITS rows with in_stall high.
// The next beat is taken while a result waits in the output register; a held output
// stalls only the result load.
module max_nonadjacent_sum_tree
	import mnst_pkg::*;
#(
	parameter int LEAVES = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [MODE_W-1:0]  mode,
	input  logic [POS_W-1:0]   position,
	input  logic [VALUE_W-1:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [SUM_W-1:0]   best_sum,
	output logic [TOTAL_W-1:0] running_total
);

	cmd_t cmd;
	sts_t sts;

	mnst_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	mnst_datapath #(
		.LEAVES(LEAVES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.mode         (mode),
		.position     (position),
		.value        (value),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.best_sum     (best_sum),
		.running_total(running_total)
	);

endmodule

// ===== design/mnst_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mnst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/mnst_datapath.sv =====
// Datapath: tree store, path walk registers, node combine, root max and total.
// Depends on mnst_pkg and mnst_ram.
module mnst_datapath
	import mnst_pkg::*;
#(
	parameter int LEAVES = 65536
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output sts_t                sts,
	input  logic [MODE_W-1:0]   mode,
	input  logic [POS_W-1:0]    position,
	input  logic [VALUE_W-1:0]  value,
	input  logic                out_stall,
	output logic                out_valid,
	output logic [SUM_W-1:0]    best_sum,
	output logic [TOTAL_W-1:0]  running_total
);

	localparam int TREE_BITS = (LEAVES > (1 << MAX_TREE_BITS)) ? MAX_TREE_BITS : $clog2(LEAVES);
	localparam int NODE_W    = TREE_BITS + 1;
	localparam int NODES     = 1 << NODE_W;

	function automatic logic [SUM_W-1:0] max2(input logic [SUM_W-1:0] a, input logic [SUM_W-1:0] b);
		return (a > b) ? a : b;
	endfunction

	function automatic logic [SUM_W-1:0] max3(input logic [SUM_W-1:0] a, input logic [SUM_W-1:0] b,
	                                          input logic [SUM_W-1:0] c);
		return max2(max2(a, b), c);
	endfunction

	// a is the left child, b the right child
	function automatic logic [ROW_W-1:0] combine(input logic [ROW_W-1:0] a, input logic [ROW_W-1:0] b);
		logic [SUM_W-1:0] ab, ar, al, an, bb, br, bl, bn;
		logic [SUM_W-1:0] pb, pr, pl, pn;
		{ab, ar, al, an} = a;
		{bb, br, bl, bn} = b;
		pb = max3(SUM_W'(ab + br), SUM_W'(al + bb), SUM_W'(al + br));
		pr = max3(SUM_W'(ar + br), SUM_W'(an + bb), SUM_W'(an + br));
		pl = max3(SUM_W'(ab + bn), SUM_W'(al + bl), SUM_W'(al + bn));
		pn = max3(SUM_W'(ar + bn), SUM_W'(an + bl), SUM_W'(an + bn));
		return {pb, pr, pl, pn};
	endfunction

	logic [NODE_W-1:0]    clr_q;
	logic [NODE_W-1:0]    node_q;
	logic [ROW_W-1:0]     cur_q;
	logic [TREE_BITS-1:0] pos_q;
	logic [VALUE_W-1:0]   value_q;
	logic                 mode_q;
	logic [SUM_W-1:0]     best_q;
	logic [TOTAL_W-1:0]   total_q;
	logic                 out_valid_q;
	logic [SUM_W-1:0]     best_sum_q;
	logic [TOTAL_W-1:0]   running_total_q;

	logic                 ram_we;
	logic [NODE_W-1:0]    ram_waddr;
	logic [ROW_W-1:0]     ram_wdata;
	logic [NODE_W-1:0]    ram_raddr;
	logic [ROW_W-1:0]     ram_rdata;

	logic [NODE_W-1:0]    leaf_idx;
	logic [NODE_W-1:0]    parent_idx;
	logic [ROW_W-1:0]     leaf_row;
	logic [ROW_W-1:0]     parent_row;
	logic [SUM_W-1:0]     root_b, root_r, root_l, root_n;
	logic [TOTAL_W:0]     sum_w;
	logic [TOTAL_W-1:0]   sat_total;

	mnst_ram #(
		.WIDTH(ROW_W),
		.DEPTH(NODES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign leaf_idx   = {1'b1, pos_q};
	assign parent_idx = node_q >> 1;
	assign leaf_row   = {SUM_W'(value_q), {(3 * SUM_W){1'b0}}};
	// current node is the left child when its index is even
	assign parent_row = node_q[0] ? combine(ram_rdata, cur_q) : combine(cur_q, ram_rdata);
	assign {root_b, root_r, root_l, root_n} = cur_q;

	assign sum_w     = {1'b0, total_q} + (TOTAL_W + 1)'(best_q);
	assign sat_total = sum_w[TOTAL_W] ? {TOTAL_W{1'b1}} : sum_w[TOTAL_W-1:0];

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		ram_raddr = leaf_idx ^ NODE_W'(1);
		if (cmd.clr_step) begin
			ram_we = 1'b1;
		end else if (cmd.leaf) begin
			ram_we    = 1'b1;
			ram_waddr = leaf_idx;
			ram_wdata = leaf_row;
		end else if (cmd.climb) begin
			ram_we    = 1'b1;
			ram_waddr = parent_idx;
			ram_wdata = parent_row;
			ram_raddr = parent_idx ^ NODE_W'(1);
		end else if (cmd.root_rd) begin
			ram_raddr = NODE_W'(1);
		end
	end

	always_comb begin
		sts.clear_last = &clr_q;
		sts.in_range   = (32'(position) < LEAVES);
		sts.at_top     = (parent_idx == NODE_W'(1));
		sts.out_free   = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + NODE_W'(1);
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
				if (mode_q) begin
					total_q <= sat_total;
				end
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= mode[0];
			pos_q   <= position[TREE_BITS-1:0];
			value_q <= value;
		end
		if (cmd.leaf) begin
			cur_q  <= leaf_row;
			node_q <= leaf_idx;
		end else if (cmd.climb) begin
			cur_q  <= parent_row;
			node_q <= parent_idx;
		end else if (cmd.root_ld) begin
			cur_q <= ram_rdata;
		end
		if (cmd.best) begin
			best_q <= max2(max2(root_b, root_r), max2(root_l, root_n));
		end
		if (cmd.finish) begin
			best_sum_q      <= best_q;
			running_total_q <= mode_q ? sat_total : total_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign best_sum      = best_sum_q;
	assign running_total = running_total_q;

`ifndef SYNTHESIS
	a_climb_above_root: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.climb |-> (node_q > NODE_W'(1)))
		else $error("climb step issued at or above the root");

	a_valid_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.finish))
		else $error("output beat raised without a finish step");

	a_total_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (total_q >= $past(total_q)))
		else $error("running total decreased");
`endif

endmodule

// ===== design/mnst_ctrl.sv =====
// Controller: sequences the clearing pass, leaf write, path climb or root read, and result.
// Depends on mnst_pkg.
module mnst_ctrl
	import mnst_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   accept;

	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = sts.in_range ? ST_LEAF : ST_ROOT_RD;
			end
			ST_LEAF:    state_d = ST_CLIMB;
			ST_CLIMB: begin
				if (sts.at_top) state_d = ST_BEST;
			end
			ST_ROOT_RD: state_d = ST_ROOT_LD;
			ST_ROOT_LD: state_d = ST_BEST;
			ST_BEST:    state_d = ST_FINISH;
			ST_FINISH: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default:    state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_CLEAR:   cmd.clr_step = 1'b1;
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_LEAF:    cmd.leaf = 1'b1;
			ST_CLIMB:   cmd.climb = 1'b1;
			ST_ROOT_RD: cmd.root_rd = 1'b1;
			ST_ROOT_LD: cmd.root_ld = 1'b1;
			ST_BEST:    cmd.best = 1'b1;
			ST_FINISH:  cmd.finish = sts.out_free;
			default:    cmd = '0;
		endcase
	end

`ifndef SYNTHESIS
	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_LEAF || state_q == ST_ROOT_RD))
		else $error("accepted beat not dispatched to leaf write or root read");

	a_climb_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLIMB && sts.at_top) |=> (state_q == ST_BEST))
		else $error("climb did not stop at the root");

	a_finish_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> sts.out_free)
		else $error("result loaded while output slot still holds a beat");
`endif

endmodule
